// File: design/lspq_pkg.sv
// Shared types, constants and result status codes for the linear scan priority queue.
package lspq_pkg;

    // Fixed field widths of the item and result transfers.
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_CAPACITY   = 16;
    localparam int DEFAULT_VALUE_BITS = 32;

    // Operation codes.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic                       valid;
        logic signed [DATA_W-1:0]   value;
        logic [STATUS_W-1:0]        status;
        logic [OCC_W-1:0]           occupancy;
    } result_t;

endpackage

// File: design/lspq_ram.sv
// Entry memory: one write port and one read port with registered read data.
module lspq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read both take effect at the clock edge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/lspq_ctrl.sv
// Sequencer: appends entries, scans for the highest priority and compacts the memory.
module lspq_ctrl #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic signed [lspq_pkg::DATA_W-1:0]    item_value,
    input  logic signed [lspq_pkg::PRIO_W-1:0]    item_priority,
    input  logic                                  out_free,
    output lspq_pkg::result_t                     result,
    output logic                                  wr_en,
    output logic [$clog2(CAPACITY)-1:0]           wr_addr,
    output logic [VALUE_BITS+lspq_pkg::PRIO_W-1:0] wr_data,
    output logic [$clog2(CAPACITY)-1:0]           rd_addr,
    input  logic [VALUE_BITS+lspq_pkg::PRIO_W-1:0] rd_data
);

    import lspq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = VALUE_BITS + PRIO_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;
    logic signed [PRIO_W-1:0]   best_prio_reg, best_prio_next;
    logic signed [DATA_W-1:0]   res_value_reg, res_value_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;

    logic                       accept;
    logic                       full;
    logic [63:0]                item_ext;
    logic [63:0]                rd_value_ext;
    logic signed [PRIO_W-1:0]   rd_prio;
    logic                       take;
    logic [AW-1:0]              best_idx_now;
    logic signed [PRIO_W-1:0]   best_prio_now;
    logic signed [DATA_W-1:0]   best_value_now;
    logic                       scan_last;
    logic                       best_is_last;
    logic                       shift_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign full     = (count_reg == CW'(CAPACITY));

    // Stored words are VALUE_BITS wide; widen through 64 bits in both directions.
    assign item_ext     = {32'b0, item_value};
    assign rd_value_ext = 64'(rd_data[EW-1:PRIO_W]);
    assign rd_prio      = signed'(rd_data[PRIO_W-1:0]);

    // Scan compare: strictly greater keeps the earliest arrival on ties.
    assign take           = (idx_reg == '0) || (rd_prio > best_prio_reg);
    assign best_idx_now   = take ? idx_reg : best_idx_reg;
    assign best_prio_now  = take ? rd_prio : best_prio_reg;
    assign best_value_now = take ? signed'(rd_value_ext[DATA_W-1:0]) : res_value_reg;
    assign scan_last      = (CW'(idx_reg) + CW'(1) == count_reg);
    assign best_is_last   = (CW'(best_idx_now) + CW'(1) == count_reg);
    assign shift_last     = (CW'(idx_reg) + CW'(2) == count_reg);

    // Next-state and memory port logic.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = {item_ext[VALUE_BITS-1:0], item_priority};
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = STATUS_OK;
                    idx_next        = '0;
                    state_next      = ST_FINISH;
                    if (operation == OP_ENQUEUE)
                    begin
                        if (full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                best_idx_next  = best_idx_now;
                best_prio_next = best_prio_now;
                res_value_next = best_value_now;
                if (scan_last)
                begin
                    if (best_is_last)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = best_idx_now;
                        rd_addr    = best_idx_now + AW'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = idx_reg + AW'(1);
                end
            end

            ST_SHIFT:
            begin
                // Move the entry read last cycle down by one place.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (shift_last)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = idx_reg + AW'(2);
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Scan pointers and result payload.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    // The result leaves once the output register can take the transfer.
    assign result.valid     = (state_reg == ST_FINISH) && out_free;
    assign result.value     = res_value_reg;
    assign result.status    = res_status_reg;
    assign result.occupancy = OCC_W'(count_reg);

    // Occupancy never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // An enqueue into a queue with room grows the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_ENQUEUE && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("enqueue did not grow the count");

    // Compaction writes stay inside the stored entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (CW'(wr_addr) + CW'(1) < count_reg))
        else $error("compaction write beyond stored entries");

    // An empty result carries a zero value and zero occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_EMPTY)
        |-> (result.value == '0 && result.occupancy == '0))
        else $error("empty result with data");

endmodule

// File: design/linear_scan_priority_queue.sv
// Top level: bounded priority queue with entry memory, sequencer and output register.
// Timing: an enqueue, a full enqueue or an empty dequeue goes from its transfer to the finish
// state and then loads the output register. A dequeue scans every stored entry through the
// single memory read port, compacts the entries above the winner down by one place and finishes.
// A new item is taken the cycle after the previous result loads the output register, so no
// item is taken while one is in progress, and a result waits while the output register is
// stalled. Reset clears the count; memory is not cleared.
module linear_scan_priority_queue #(
    parameter int CAPACITY   = lspq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = lspq_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic signed [lspq_pkg::DATA_W-1:0]    item_value,
    input  logic signed [lspq_pkg::PRIO_W-1:0]    item_priority,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lspq_pkg::DATA_W-1:0]    out_value,
    output logic [lspq_pkg::STATUS_W-1:0]         status,
    output logic [lspq_pkg::OCC_W-1:0]            occupancy
);

    import lspq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = VALUE_BITS + PRIO_W;

    result_t                    result;
    logic                       out_free;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [EW-1:0]              wr_data;
    logic [AW-1:0]              rd_addr;
    logic [EW-1:0]              rd_data;

    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [OCC_W-1:0]           occupancy_reg;

    lspq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lspq_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_free      (out_free),
        .result        (result),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // The output register can load when empty or when its transfer completes now.
    assign out_free = !out_valid_reg || !out_stall;

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_value_reg <= result.value;
            status_reg    <= result.status;
            occupancy_reg <= result.occupancy;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

// File: dv/lspq_checker.sv
// Transfer monitor, result predictor and scoreboard for the linear scan priority queue.
`timescale 1ns / 100ps

module lspq_checker #(
    parameter int CAPACITY = lspq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  operation,
    input  logic signed [lspq_pkg::DATA_W-1:0]    item_value,
    input  logic signed [lspq_pkg::PRIO_W-1:0]    item_priority,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [lspq_pkg::DATA_W-1:0]    out_value,
    input  logic [lspq_pkg::STATUS_W-1:0]         status,
    input  logic [lspq_pkg::OCC_W-1:0]            occupancy,
    output int                                    fail_count,
    output int                                    pending_count
);

    import lspq_pkg::*;

    // One predicted result of an item.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
    } queue_result_t;

    // Shadow copy of the queue contents in arrival order.
    logic signed [DATA_W-1:0] shadow_value [CAPACITY];
    logic signed [PRIO_W-1:0] shadow_priority [CAPACITY];
    int                       shadow_count = 0;

    queue_result_t            queued_results [$];
    int                       mismatch_total = 0;
    int                       waiting_total = 0;

    assign fail_count    = mismatch_total;
    assign pending_count = waiting_total;

    // Apply one item to the shadow queue and work out the result it must give.
    task automatic serve_item(input logic op, input logic signed [DATA_W-1:0] val,
                              input logic signed [PRIO_W-1:0] prio,
                              output queue_result_t res);
        int winner;
        res.value  = '0;
        res.status = STATUS_OK;
        if (op == OP_ENQUEUE)
        begin
            if (shadow_count >= CAPACITY)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                shadow_value[shadow_count]    = val;
                shadow_priority[shadow_count] = prio;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            // Strictly larger wins, so the earliest arrival keeps a tie.
            winner = 0;
            for (int i = 1; i < shadow_count; i++)
            begin
                if (shadow_priority[i] > shadow_priority[winner])
                    winner = i;
            end
            res.value = shadow_value[winner];
            for (int i = winner; i < shadow_count - 1; i++)
            begin
                shadow_value[i]    = shadow_value[i + 1];
                shadow_priority[i] = shadow_priority[i + 1];
            end
            shadow_count--;
        end
        res.occupancy = shadow_count[OCC_W-1:0];
    endtask

    // Check result transfers against the oldest prediction, then predict new items.
    always @(posedge clk)
    begin : monitor
        queue_result_t predicted;
        queue_result_t oldest;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (queued_results.size() == 0)
                begin
                    $display("%0t: result transfer with no item pending: %s %0d %0d %0d",
                             $time, "value status occupancy", out_value, status,
                             occupancy);
                    mismatch_total++;
                end
                else
                begin
                    oldest = queued_results.pop_front();
                    if (out_value !== oldest.value)
                    begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, oldest.value, out_value);
                        mismatch_total++;
                    end
                    if (status !== oldest.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.status, status);
                        mismatch_total++;
                    end
                    if (occupancy !== oldest.occupancy)
                    begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, oldest.occupancy, occupancy);
                        mismatch_total++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                serve_item(operation, item_value, item_priority, predicted);
                queued_results.push_back(predicted);
            end
            waiting_total = queued_results.size();
        end
    end

endmodule

// File: dv/tb_linear_scan_priority_queue.sv
// Stimulus, clocking and final verdict for the linear scan priority queue testbench.
`timescale 1ns / 100ps

module tb_linear_scan_priority_queue;

    import lspq_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 200;
    localparam int BLOCK_COUNT  = 34;
    localparam int BLOCK_ITEMS  = 50;
    localparam int HOLD_BLOCK   = 4;

    // Traffic mix of one block of random items.
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BALANCED } traffic_mix_t;
    typedef enum int { PRIO_FULL, PRIO_NARROW, PRIO_EXTREME } prio_style_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       operation;
    logic signed [DATA_W-1:0]   item_value;
    logic signed [PRIO_W-1:0]   item_priority;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   out_value;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;

    int                         fail_count;
    int                         pending_count;
    int                         cycle_count = 0;
    bit                         idle_off = 1'b0;
    bit                         hold_off_req = 1'b0;

    linear_scan_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .status        (status),
        .occupancy     (occupancy)
    );

    lspq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .status        (status),
        .occupancy     (occupancy),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_linear_scan_priority_queue failed");
            $finish;
        end
    end

    // Idle length: eight draws in ten come from the short range, the rest from the long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_priority(prio_style_t style);
        logic signed [PRIO_W-1:0] prio;
        case (style)
            PRIO_NARROW:  prio = $signed(PRIO_W'($urandom_range(0, 3))) - 16'sd2;
            PRIO_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       prio = 16'sh7FFF;
                    1:       prio = 16'sh8000;
                    2:       prio = 16'sh0000;
                    default: prio = 16'shFFFF;
                endcase
            end
            default:      prio = PRIO_W'($urandom_range(0, 65535));
        endcase
        return prio;
    endfunction

    // Offer one item, with an optional idle gap first, and wait for its transfer.
    task automatic send_item(input logic op, input logic signed [DATA_W-1:0] val,
                             input logic signed [PRIO_W-1:0] prio);
        int gap;
        gap = (idle_off || $urandom_range(0, 9) < 7) ? 0 : idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        operation     <= op;
        item_value    <= val;
        item_priority <= prio;
        do @(posedge clk); while (in_stall);
    endtask

    // Result side: random stalls, a long hold-off on request, none while idling is off.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = LONG_HOLD - 1;
                out_stall   <= 1'b1;
            end
            else if (!idle_off && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_length() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        traffic_mix_t mix;
        prio_style_t  style;
        int           enqueue_pct;
        logic         op;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_ENQUEUE;
        item_value    = '0;
        item_priority = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty dequeue, field extremes, ties, a full queue, then a partial drain.
        send_item(OP_DEQUEUE, 32'h0000_0000, 16'h0000);
        send_item(OP_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
        send_item(OP_ENQUEUE, 32'h8000_0000, 16'h8000);
        send_item(OP_ENQUEUE, 32'h0000_0000, 16'h0000);
        send_item(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_ENQUEUE, 32'h0000_0001, 16'h0001);
        send_item(OP_ENQUEUE, 32'h1234_5678, 16'h7FFF);
        send_item(OP_ENQUEUE, 32'hAAAA_AAAA, 16'h0005);
        send_item(OP_ENQUEUE, 32'h5555_5555, 16'h0005);
        send_item(OP_ENQUEUE, 32'hDEAD_BEEF, 16'h0005);
        send_item(OP_ENQUEUE, 32'hCAFE_F00D, 16'h8000);
        for (int k = 0; k < 6; k++)
            send_item(OP_ENQUEUE, $urandom, 16'h5555 ^ {16{k[0]}});
        send_item(OP_ENQUEUE, 32'h1357_9BDF, 16'h7FFF);
        for (int k = 0; k < 7; k++)
            send_item(OP_DEQUEUE, $urandom, 16'h7FFF);

        // Random blocks, each with its own traffic mix and priority spread.
        for (int b = 0; b < BLOCK_COUNT; b++)
        begin
            mix      = traffic_mix_t'($urandom_range(0, 2));
            style    = prio_style_t'($urandom_range(0, 2));
            idle_off = ($urandom_range(0, 4) == 0);
            if (b == HOLD_BLOCK)
            begin
                // Stall the result side for a long stretch while further items are offered.
                mix          = MIX_FILL;
                idle_off     = 1'b1;
                hold_off_req = 1'b1;
            end
            case (mix)
                MIX_FILL:  enqueue_pct = 80;
                MIX_DRAIN: enqueue_pct = 20;
                default:   enqueue_pct = 50;
            endcase
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                op = ($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                send_item(op, $urandom, pick_priority(style));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        idle_off  = 1'b0;

        // Let the last results drain, then allow a short tail.
        while (pending_count > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb_linear_scan_priority_queue passed");
        else
            $display("tb_linear_scan_priority_queue failed");
        $finish;
    end

endmodule
